### rtl/orl_pkg.sv
// ----------------------------------------------------------------------------
// Ordered record list package
// Shared widths, command and status codes, the record type and cell control.
// ----------------------------------------------------------------------------
package orl_pkg;

    localparam int CAPACITY_DEF = 8;
    localparam int KEY_CHARS    = 8;

    localparam int CMD_W    = 3;
    localparam int TEXT_W   = 64;
    localparam int RATING_W = 48;
    localparam int DUR_W    = 16;
    localparam int PRICE_W  = 24;
    localparam int POS_W    = 3;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 3;
    localparam int COUNT_W  = 4;

    // Only the low key characters take part in a title compare
    localparam logic [TEXT_W-1:0] KEY_MASK = {TEXT_W{1'b1}} >> (TEXT_W - 8 * KEY_CHARS);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_PREPEND = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_SEARCH  = 3'd4,
        CMD_UPDATE  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_POS   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_REMOVE,
        ACT_WRITE
    } action_t;

    typedef struct packed {
        logic [TEXT_W-1:0]   title;
        logic [TEXT_W-1:0]   genre;
        logic [RATING_W-1:0] age_rating;
        logic [DUR_W-1:0]    duration_min;
        logic [PRICE_W-1:0]  price_cents;
        logic                available;
    } rec_t;

    typedef struct packed {
        logic    compare;
        action_t action;
    } cell_ctl_t;

endpackage

### rtl/orl_in_if.sv
// ----------------------------------------------------------------------------
// Ordered record list command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface orl_in_if;

    logic                             valid;
    logic                             ready;
    logic [orl_pkg::CMD_W-1:0]        command;
    logic [orl_pkg::TEXT_W-1:0]       search_title;
    logic [orl_pkg::TEXT_W-1:0]       title;
    logic [orl_pkg::TEXT_W-1:0]       genre;
    logic [orl_pkg::RATING_W-1:0]     age_rating;
    logic [orl_pkg::DUR_W-1:0]        duration_min;
    logic [orl_pkg::PRICE_W-1:0]      price_cents;
    logic                             available;
    logic [orl_pkg::POS_W-1:0]        position;

    modport source (
        output valid, command, search_title, title, genre, age_rating,
               duration_min, price_cents, available, position,
        input  ready
    );

    modport sink (
        input  valid, command, search_title, title, genre, age_rating,
               duration_min, price_cents, available, position,
        output ready
    );

endinterface

### rtl/orl_out_if.sv
// ----------------------------------------------------------------------------
// Ordered record list result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface orl_out_if;

    logic                          valid;
    logic                          ready;
    logic [orl_pkg::STATUS_W-1:0]  status;
    logic [orl_pkg::INDEX_W-1:0]   index;
    logic [orl_pkg::COUNT_W-1:0]   count;

    modport source (
        output valid, status, index, count,
        input  ready
    );

    modport sink (
        input  valid, status, index, count,
        output ready
    );

endinterface

### rtl/orl_cell.sv
// ----------------------------------------------------------------------------
// Ordered record list cell
// Holds one record, compares its title and shifts with its neighbours.
// ----------------------------------------------------------------------------
module orl_cell #(
    parameter int IDX = 0,
    parameter int IW  = 3,
    parameter int CW  = 4
) (
    input  logic                        clk,
    input  orl_pkg::cell_ctl_t          ctl,
    input  logic [IW-1:0]               target,
    input  logic [CW-1:0]               count,
    input  logic [orl_pkg::TEXT_W-1:0]  key,
    input  orl_pkg::rec_t               new_rec,
    input  orl_pkg::rec_t               left_rec,
    input  orl_pkg::rec_t               right_rec,
    input  logic                        hit_in,
    output logic                        hit_out,
    output logic                        first,
    output orl_pkg::rec_t               rec
);

    orl_pkg::rec_t rec_reg;
    orl_pkg::rec_t rec_next;
    logic          match_reg;
    logic          occupied;
    logic          at_target;
    logic          above_target;

    assign occupied     = CW'(IDX) < count;
    assign at_target    = IW'(IDX) == target;
    assign above_target = IW'(IDX) > target;

    // First match in index order ripples along the row
    assign first   = match_reg & occupied & ~hit_in;
    assign hit_out = hit_in | (match_reg & occupied);
    assign rec     = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        case (ctl.action)
            orl_pkg::ACT_INSERT:
            begin
                if (at_target)
                begin
                    rec_next = new_rec;
                end
                else if (above_target)
                begin
                    rec_next = left_rec;
                end
            end
            orl_pkg::ACT_REMOVE:
            begin
                if (at_target || above_target)
                begin
                    rec_next = right_rec;
                end
            end
            orl_pkg::ACT_WRITE:
            begin
                if (at_target)
                begin
                    rec_next = new_rec;
                end
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (ctl.compare)
        begin
            match_reg <= (rec_reg.title & orl_pkg::KEY_MASK) == (key & orl_pkg::KEY_MASK);
        end
    end

endmodule

### rtl/orl_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered record list controller
// Latches a command, sequences compare and apply, and holds the result word.
// ----------------------------------------------------------------------------
module orl_ctrl #(
    parameter int CAPACITY = orl_pkg::CAPACITY_DEF,
    parameter int IW       = 3,
    parameter int CW       = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    orl_in_if.sink                      in_ch,
    orl_out_if.source                   out_ch,
    input  logic [CAPACITY-1:0]         first_hit,
    output orl_pkg::cell_ctl_t          ctl,
    output logic [IW-1:0]               target,
    output logic [CW-1:0]               count,
    output logic [orl_pkg::TEXT_W-1:0]  key,
    output orl_pkg::rec_t               new_rec
);

    localparam int PCW = (orl_pkg::POS_W > CW) ? orl_pkg::POS_W : CW;

    orl_pkg::state_t                 state_reg;
    orl_pkg::state_t                 state_next;
    logic [orl_pkg::CMD_W-1:0]       cmd_reg;
    logic [orl_pkg::TEXT_W-1:0]      key_reg;
    orl_pkg::rec_t                   rec_reg;
    logic [orl_pkg::POS_W-1:0]       pos_reg;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    orl_pkg::status_t                status_reg;
    orl_pkg::status_t                status_next;
    logic [orl_pkg::INDEX_W-1:0]     index_reg;
    logic [orl_pkg::INDEX_W-1:0]     index_next;
    logic [orl_pkg::COUNT_W-1:0]     count_out_reg;
    logic [orl_pkg::COUNT_W-1:0]     count_out_next;
    logic                            accept;
    logic                            exec_go;
    logic                            found;
    logic [IW-1:0]                   found_idx;
    logic                            full;
    logic                            bad_pos;

    assign in_ch.ready  = state_reg == orl_pkg::S_IDLE;
    assign accept       = in_ch.valid & in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.status = status_reg;
    assign out_ch.index  = index_reg;
    assign out_ch.count  = count_out_reg;

    assign count   = count_reg;
    assign key     = key_reg;
    assign new_rec = rec_reg;

    assign exec_go = (state_reg == orl_pkg::S_EXEC) & (~out_valid_reg | out_ch.ready);
    assign found   = |first_hit;
    assign full    = count_reg == CW'(CAPACITY);
    assign bad_pos = PCW'(pos_reg) >= PCW'(count_reg);

    always_comb
    begin
        found_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_hit[i])
            begin
                found_idx = found_idx | IW'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        count_out_next = count_out_reg;
        ctl.compare    = 1'b0;
        ctl.action     = orl_pkg::ACT_NONE;
        target         = '0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            orl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = orl_pkg::S_MATCH;
                end
            end
            orl_pkg::S_MATCH:
            begin
                ctl.compare = 1'b1;
                state_next  = orl_pkg::S_EXEC;
            end
            orl_pkg::S_EXEC:
            begin
                status_next = orl_pkg::ST_OK;
                case (orl_pkg::cmd_t'(cmd_reg))
                    orl_pkg::CMD_APPEND,
                    orl_pkg::CMD_PREPEND,
                    orl_pkg::CMD_INSERT:
                    begin
                        if (orl_pkg::cmd_t'(cmd_reg) == orl_pkg::CMD_APPEND)
                        begin
                            target = IW'(count_reg);
                        end
                        else if (orl_pkg::cmd_t'(cmd_reg) == orl_pkg::CMD_INSERT)
                        begin
                            target = IW'(pos_reg);
                        end
                        if (full)
                        begin
                            status_next = orl_pkg::ST_FULL;
                            target      = '0;
                        end
                        else if (orl_pkg::cmd_t'(cmd_reg) == orl_pkg::CMD_INSERT && bad_pos)
                        begin
                            status_next = orl_pkg::ST_BAD_POS;
                            target      = '0;
                        end
                        else
                        begin
                            ctl.action = orl_pkg::ACT_INSERT;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    orl_pkg::CMD_REMOVE:
                    begin
                        target = found_idx;
                        if (found)
                        begin
                            ctl.action = orl_pkg::ACT_REMOVE;
                            count_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            status_next = orl_pkg::ST_NOT_FOUND;
                        end
                    end
                    orl_pkg::CMD_SEARCH:
                    begin
                        target = found_idx;
                        if (!found)
                        begin
                            status_next = orl_pkg::ST_NOT_FOUND;
                        end
                    end
                    orl_pkg::CMD_UPDATE:
                    begin
                        target = found_idx;
                        if (found)
                        begin
                            ctl.action = orl_pkg::ACT_WRITE;
                        end
                        else
                        begin
                            status_next = orl_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        target = '0;
                    end
                endcase
                index_next     = orl_pkg::INDEX_W'(target);
                count_out_next = orl_pkg::COUNT_W'(count_next);

                // Hold everything while the previous word is still unclaimed
                if (exec_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = orl_pkg::S_IDLE;
                end
                else
                begin
                    ctl.action     = orl_pkg::ACT_NONE;
                    count_next     = count_reg;
                    status_next    = status_reg;
                    index_next     = index_reg;
                    count_out_next = count_out_reg;
                end
            end
            default:
            begin
                state_next = orl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= orl_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg              <= in_ch.command;
            key_reg              <= in_ch.search_title;
            pos_reg              <= in_ch.position;
            rec_reg.title        <= in_ch.title;
            rec_reg.genre        <= in_ch.genre;
            rec_reg.age_rating   <= in_ch.age_rating;
            rec_reg.duration_min <= in_ch.duration_min;
            rec_reg.price_cents  <= in_ch.price_cents;
            rec_reg.available    <= in_ch.available;
        end
        status_reg    <= status_next;
        index_reg     <= index_next;
        count_out_reg <= count_out_next;
    end

endmodule

### rtl/ordered_record_list_top.sv
// ----------------------------------------------------------------------------
// Ordered record list
// Fixed-capacity ordered list of records held in a row of cells.
// ----------------------------------------------------------------------------
// The title compare is registered in the match state; the first-match ripple along the
// cell row, the shift into neighbours and the raising of result valid follow in the
// exec state, which waits while the previous result word is unclaimed. A new command is taken only in idle.
// Reset: clears the record count and the result valid; record contents are
// left as they are and are only read once written.
module ordered_record_list_top #(
    parameter int CAPACITY = orl_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    orl_in_if.sink    in_ch,
    orl_out_if.source out_ch
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    orl_pkg::cell_ctl_t          ctl;
    logic [IW-1:0]               target;
    logic [CW-1:0]               count;
    logic [orl_pkg::TEXT_W-1:0]  key;
    orl_pkg::rec_t               new_rec;
    orl_pkg::rec_t               rec_w [CAPACITY];
    logic [CAPACITY:0]           hit_chain;
    logic [CAPACITY-1:0]         first_hit;

    assign hit_chain[0] = 1'b0;

    orl_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .first_hit (first_hit),
        .ctl       (ctl),
        .target    (target),
        .count     (count),
        .key       (key),
        .new_rec   (new_rec)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        orl_pkg::rec_t left_rec;
        orl_pkg::rec_t right_rec;

        // The first cell sees the new record on its left, the last cell sees itself on its right
        if (i == 0)
        begin : g_left_edge
            assign left_rec = new_rec;
        end
        else
        begin : g_left
            assign left_rec = rec_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_right_edge
            assign right_rec = rec_w[i];
        end
        else
        begin : g_right
            assign right_rec = rec_w[i+1];
        end

        orl_cell #(
            .IDX (i),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .target    (target),
            .count     (count),
            .key       (key),
            .new_rec   (new_rec),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .hit_in    (hit_chain[i]),
            .hit_out   (hit_chain[i+1]),
            .first     (first_hit[i]),
            .rec       (rec_w[i])
        );
    end

endmodule

### tb/tb_ordered_record_list_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered record list testbench
// Sends list commands through the command channel and predicts each result
// from a local copy of the list. Every returned word is checked against the
// oldest prediction. Both channels idle at random, and the result side is
// held off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_ordered_record_list_top;

    import orl_pkg::*;

    localparam int SLOTS           = CAPACITY_DEF;
    localparam int POOL_SIZE       = 16;
    localparam int MAX_IDLE        = 16;
    localparam int RANDOM_WORDS    = 1500;
    localparam int MIX_SPAN        = 40;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;

    // Command codes the block must accept and ignore
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef enum {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [TEXT_W-1:0] search_title;
        rec_t              rec;
        logic [POS_W-1:0]  position;
    } shelf_cmd_t;

    typedef struct {
        status_t            status;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
    } shelf_res_t;

    logic clk = 1'b0;
    logic rst_n;

    orl_in_if  cmd_ch ();
    orl_out_if res_ch ();

    ordered_record_list_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (res_ch)
    );

    always #10 clk = ~clk;

    rec_t              shelf [SLOTS];
    int                shelf_len = 0;
    shelf_cmd_t        cmd_backlog [$];
    shelf_res_t        awaited_results [$];
    logic [TEXT_W-1:0] title_pool [POOL_SIZE];
    shelf_cmd_t        word_on_bus;

    int send_gap        = 0;
    int recv_stall      = 0;
    bit send_burst      = 1'b0;
    bit recv_burst      = 1'b0;
    int words_total     = 0;
    int words_accepted  = 0;
    int results_checked = 0;
    int failures        = 0;
    int pressure_left   = 0;
    bit pressure_done   = 1'b0;
    int cmd_seen [8]    = '{default: 0};
    int status_seen [4] = '{default: 0};

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int draw_idle(bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic shelf_cmd_t make_cmd(logic [CMD_W-1:0] op, logic [TEXT_W-1:0] key,
                                            logic [TEXT_W-1:0] ttl, logic [POS_W-1:0] pos);
        shelf_cmd_t c;
        c.command             = op;
        c.search_title        = key;
        c.position            = pos;
        c.rec.title           = ttl;
        c.rec.genre           = rand64();
        c.rec.age_rating      = {16'($urandom), $urandom};
        c.rec.duration_min    = 16'($urandom);
        c.rec.price_cents     = 24'($urandom);
        c.rec.available       = 1'($urandom);
        return c;
    endfunction

    // Apply one command to the local list and return the result it yields
    function automatic shelf_res_t apply_to_shelf(shelf_cmd_t c);
        shelf_res_t r;
        int         slot;
        int         hit;
        r.status = ST_OK;
        r.index  = '0;
        hit      = -1;
        for (int i = 0; i < shelf_len; i++)
        begin
            if (hit < 0 && (shelf[i].title & KEY_MASK) == (c.search_title & KEY_MASK))
                hit = i;
        end
        case (c.command)
            CMD_APPEND, CMD_PREPEND, CMD_INSERT:
            begin
                if (c.command == CMD_APPEND)
                    slot = shelf_len;
                else if (c.command == CMD_PREPEND)
                    slot = 0;
                else
                    slot = int'(c.position);
                if (shelf_len >= SLOTS)
                    r.status = ST_FULL;
                else if (c.command == CMD_INSERT && slot >= shelf_len)
                    r.status = ST_BAD_POS;
                else
                begin
                    for (int i = shelf_len; i > slot; i--)
                        shelf[i] = shelf[i-1];
                    shelf[slot] = c.rec;
                    shelf_len++;
                    r.index = INDEX_W'(slot);
                end
            end
            CMD_REMOVE:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    // close the gap behind the removed record
                    for (int i = hit; i + 1 < shelf_len; i++)
                        shelf[i] = shelf[i+1];
                    shelf_len--;
                    r.index = INDEX_W'(hit);
                end
            end
            CMD_SEARCH:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    r.index = INDEX_W'(hit);
            end
            CMD_UPDATE:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    shelf[hit] = c.rec;
                    r.index = INDEX_W'(hit);
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(shelf_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        logic offer;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            offer = cmd_ch.valid;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                awaited_results.push_back(apply_to_shelf(word_on_bus));
                cmd_seen[word_on_bus.command]++;
                words_accepted++;
                offer = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    send_burst = !send_burst;
                send_gap = draw_idle(send_burst);
            end
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (cmd_backlog.size() > 0)
                begin
                    word_on_bus = cmd_backlog.pop_front();
                    cmd_ch.command      <= word_on_bus.command;
                    cmd_ch.search_title <= word_on_bus.search_title;
                    cmd_ch.title        <= word_on_bus.rec.title;
                    cmd_ch.genre        <= word_on_bus.rec.genre;
                    cmd_ch.age_rating   <= word_on_bus.rec.age_rating;
                    cmd_ch.duration_min <= word_on_bus.rec.duration_min;
                    cmd_ch.price_cents  <= word_on_bus.rec.price_cents;
                    cmd_ch.available    <= word_on_bus.rec.available;
                    cmd_ch.position     <= word_on_bus.position;
                    offer = 1'b1;
                end
            end
            cmd_ch.valid <= offer;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : res_monitor
        shelf_res_t want;
        logic       take;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                status_seen[res_ch.status]++;
                results_checked <= results_checked + 1;
                if (awaited_results.size() == 0)
                begin
                    failures++;
                    $error("unexpected result word: status %0d index %0d count %0d",
                           res_ch.status, res_ch.index, res_ch.count);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (res_ch.status !== want.status)
                    begin
                        failures++;
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                    end
                    if (res_ch.index !== want.index)
                    begin
                        failures++;
                        $error("index: expected %0d, got %0d", want.index, res_ch.index);
                    end
                    if (res_ch.count !== want.count)
                    begin
                        failures++;
                        $error("count: expected %0d, got %0d", want.count, res_ch.count);
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                recv_stall = draw_idle(recv_burst);
            end
            if (pressure_left > 0)
                take = 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall--;
                take = 1'b0;
            end
            else
                take = 1'b1;
            res_ch.ready <= take;
        end
    end

    // Hold the result side off once, well into the run, so the block backs up
    always @(posedge clk or negedge rst_n)
    begin : hold_off
        if (!rst_n)
        begin
            pressure_left <= 0;
            pressure_done <= 1'b0;
        end
        else if (!pressure_done && results_checked >= HOLD_OFF_AT)
        begin
            pressure_left <= HOLD_OFF_CYCLES;
            pressure_done <= 1'b1;
        end
        else if (pressure_left > 0)
            pressure_left <= pressure_left - 1;
    end

    initial
    begin : stimulus
        shelf_cmd_t       c;
        mix_t             mix;
        int               pick;
        int               cut [6];
        logic [CMD_W-1:0] op;
        logic [TEXT_W-1:0] key;

        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = '0;
        cmd_ch.search_title = '0;
        cmd_ch.title        = '0;
        cmd_ch.genre        = '0;
        cmd_ch.age_rating   = '0;
        cmd_ch.duration_min = '0;
        cmd_ch.price_cents  = '0;
        cmd_ch.available    = 1'b0;
        cmd_ch.position     = '0;
        res_ch.ready        = 1'b0;

        title_pool[0] = '0;
        title_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            title_pool[k] = rand64();

        // empty list: lookups miss, insert at position 0 is past the end and is refused
        cmd_backlog.push_back(make_cmd(CMD_SEARCH, title_pool[0], title_pool[0], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_REMOVE, title_pool[1], title_pool[1], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_UPDATE, title_pool[2], title_pool[2], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, title_pool[0], title_pool[2], 3'd0));
        c = make_cmd(CMD_APPEND, '1, '1, '1);
        c.rec = '1;
        cmd_backlog.push_back(c);
        c = make_cmd(CMD_PREPEND, '0, '0, '0);
        c.rec = '0;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(CMD_INSERT, title_pool[2], title_pool[2], 3'd1));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, title_pool[3], title_pool[3], 3'd7));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, title_pool[3], title_pool[3], 3'd2));
        cmd_backlog.push_back(make_cmd(CMD_SPARE_A, title_pool[2], title_pool[5], 3'd1));
        cmd_backlog.push_back(make_cmd(CMD_SPARE_B, title_pool[3], title_pool[6], 3'd0));
        // fill up, last one a duplicate title
        for (int k = 4; k < 7; k++)
            cmd_backlog.push_back(make_cmd(CMD_APPEND, title_pool[k], title_pool[k], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_APPEND, title_pool[2], title_pool[2], 3'd0));
        // full list refuses every kind of add
        cmd_backlog.push_back(make_cmd(CMD_APPEND, title_pool[7], title_pool[7], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_PREPEND, title_pool[7], title_pool[7], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, title_pool[7], title_pool[7], 3'd7));
        // first match wins on duplicates
        cmd_backlog.push_back(make_cmd(CMD_SEARCH, title_pool[2], title_pool[2], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_UPDATE, '0, title_pool[8], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_SEARCH, '1, title_pool[8], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_REMOVE, title_pool[2], title_pool[2], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_REMOVE, title_pool[2], title_pool[2], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_SEARCH, title_pool[2], title_pool[2], 3'd0));
        cmd_backlog.push_back(make_cmd(CMD_REMOVE, '0, '0, 3'd0));

        // random part: spans that lean to filling, draining, or neither
        mix = MIX_EVEN;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % MIX_SPAN == 0)
                mix = mix_t'($urandom_range(0, 2));
            // cut points in command-code order, remainder goes to spare codes
            case (mix)
                MIX_FILL:  cut = '{30, 50, 75, 83, 92, 98};
                MIX_DRAIN: cut = '{8, 13, 20, 65, 85, 98};
                default:   cut = '{17, 30, 45, 65, 80, 98};
            endcase
            pick = $urandom_range(0, 99);
            op   = ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
            for (int k = 5; k >= 0; k--)
            begin
                if (pick < cut[k])
                    op = CMD_W'(k);
            end
            if ($urandom_range(0, 9) == 0)
                key = rand64();
            else
                key = title_pool[$urandom_range(0, POOL_SIZE - 1)];
            cmd_backlog.push_back(make_cmd(op, key, title_pool[$urandom_range(0, POOL_SIZE - 1)],
                                           POS_W'($urandom_range(0, 7))));
        end
        words_total = cmd_backlog.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (words_accepted < words_total || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands: %0d append, %0d prepend, %0d insert, %0d remove, %0d search,",
                 words_accepted, cmd_seen[CMD_APPEND], cmd_seen[CMD_PREPEND],
                 cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE], cmd_seen[CMD_SEARCH]);
        $display("%0d update, %0d spare; results %0d ok, %0d full, %0d missing, %0d bad position.",
                 cmd_seen[CMD_UPDATE], cmd_seen[CMD_SPARE_A] + cmd_seen[CMD_SPARE_B],
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
                 status_seen[ST_BAD_POS]);
        if (failures == 0 && awaited_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $error("run did not complete in time");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
